### rtl/dsa_pkg.sv
package dsa_pkg;

   localparam int DIGIT_W     = 4;
   localparam int CMD_W       = 2;
   localparam int RADIX       = 10;
   localparam int MAX_DIGIT   = 9;
   localparam int MAX_RESULTS = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;

   // control into an operand stack
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [DIGIT_W-1:0] digit;
   } stk_ctl_type;

   // status out of an operand stack
   typedef struct packed {
      logic empty;
      logic full;
   } stk_sts_type;

endpackage

### rtl/dsa_ram.sv
module dsa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/dsa_stack.sv
// Operand digit stack: push at the fill count, pop from the top.
// Popped digit shows on rdata in the cycle after the pop.
module dsa_stack import dsa_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  stk_ctl_type        ctl,
   output stk_sts_type        sts,
   output logic [DIGIT_W-1:0] rdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] top;
   logic          do_push, do_pop;

   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == CW'(DEPTH));
   assign do_push   = ctl.push && !sts.full;
   assign do_pop    = ctl.pop && !sts.empty;
   assign top       = count_ff - CW'(1);

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   dsa_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (do_push),
      .waddr (count_ff[AW-1:0]),
      .wdata (ctl.digit),
      .raddr (top[AW-1:0]),
      .rdata (rdata)
   );

endmodule

### rtl/decimal_digit_string_adder.sv
// channel | direction | ports                                         | handshake
// req     | in        | req_cmd, req_digit_in                         | req_valid / req_stall
// rsp     | out       | rsp_digit_out, rsp_last_digit, rsp_digit_dropped | rsp_valid / rsp_stall
//
// Loads can come back to back.
// An add item works sum digit by sum digit (stack RAM read, then add and sum RAM
// write), then finishes and emits each digit in read, wait and hold steps, plus any rsp stall;
// the separate read and wait steps come from the registered read port of each digit RAM.
// Synchronous active-high reset empties the stacks and clears carry and drop flag.
// req_stall is high for the whole add; an rsp item holds while rsp_stall is high.
module decimal_digit_string_adder import dsa_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [DIGIT_W-1:0] req_digit_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [DIGIT_W-1:0] rsp_digit_out,
   output logic               rsp_last_digit,
   output logic               rsp_digit_dropped
);

   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int MRW = $clog2(MAX_RESULTS + 1);
   localparam int RW  = (CW > MRW) ? CW : MRW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_HOLD
   } state_type;

   state_type          state_ff, state_in;
   logic               carry_ff, carry_in;
   logic               drop_ff, drop_in;
   logic [CW-1:0]      sum_count_ff, sum_count_in;
   logic               a_live_ff, a_live_in;
   logic               b_live_ff, b_live_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [RW-1:0]      rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] out_digit_ff, out_digit_in;
   logic               out_last_ff, out_last_in;
   logic               out_drop_ff, out_drop_in;

   stk_ctl_type        a_ctl, b_ctl;
   stk_sts_type        a_sts, b_sts;
   logic [DIGIT_W-1:0] a_rdata, b_rdata, sum_rdata;

   logic               req_take;
   logic [DIGIT_W-1:0] load_digit;
   logic [DIGIT_W-1:0] a_val, b_val;
   logic [DIGIT_W:0]   raw_sum;
   logic               wrap;
   logic [DIGIT_W:0]   fix_sum;
   logic               sum_room;
   logic               sum_we;
   logic [CW-1:0]      sum_top;
   logic [RW-1:0]      sum_ext;
   logic               add_done;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // digits above nine saturate
   assign load_digit = (req_digit_in > DIGIT_W'(MAX_DIGIT)) ? DIGIT_W'(MAX_DIGIT)
                                                            : req_digit_in;

   assign add_done = a_sts.empty && b_sts.empty && !carry_ff;

   always_comb begin
      a_ctl.push  = req_take && (req_cmd == CMD_LOAD_A);
      a_ctl.pop   = (state_ff == ST_ADD_RD) && !add_done;
      a_ctl.digit = load_digit;
      b_ctl.push  = req_take && (req_cmd == CMD_LOAD_B);
      b_ctl.pop   = (state_ff == ST_ADD_RD) && !add_done;
      b_ctl.digit = load_digit;
   end

   // one decimal digit step; a drained stack supplies zero
   assign a_val    = a_live_ff ? a_rdata : '0;
   assign b_val    = b_live_ff ? b_rdata : '0;
   assign raw_sum  = {1'b0, a_val} + {1'b0, b_val} + {{DIGIT_W{1'b0}}, carry_ff};
   assign wrap     = (raw_sum >= (DIGIT_W + 1)'(RADIX));
   assign fix_sum  = wrap ? raw_sum - (DIGIT_W + 1)'(RADIX) : raw_sum;
   assign sum_room = (sum_count_ff < CW'(DEPTH));
   assign sum_we   = (state_ff == ST_ADD_WR) && sum_room;
   assign sum_top  = sum_count_ff - CW'(1);
   assign sum_ext  = RW'(sum_count_ff);

   always_comb begin
      state_in     = state_ff;
      carry_in     = carry_ff;
      drop_in      = drop_ff;
      sum_count_in = sum_count_ff;
      a_live_in    = a_live_ff;
      b_live_in    = b_live_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      out_digit_in = out_digit_ff;
      out_last_in  = out_last_ff;
      out_drop_in  = out_drop_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // a load into a full stack is lost but remembered
               if ((req_cmd == CMD_LOAD_A && a_sts.full) ||
                   (req_cmd == CMD_LOAD_B && b_sts.full)) begin
                  drop_in = 1'b1;
               end
               if (req_cmd == CMD_ADD) begin
                  carry_in     = 1'b0;
                  sum_count_in = '0;
                  state_in     = ST_ADD_RD;
               end
            end
         end
         ST_ADD_RD: begin
            if (add_done) begin
               if (sum_count_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = sum_top[AW-1:0];
                  rem_in   = (sum_ext > RW'(MAX_RESULTS)) ? RW'(MAX_RESULTS) : sum_ext;
                  state_in = ST_EMIT_RD;
               end
            end else begin
               a_live_in = !a_sts.empty;
               b_live_in = !b_sts.empty;
               state_in  = ST_ADD_WR;
            end
         end
         ST_ADD_WR: begin
            carry_in = wrap;
            if (sum_room) begin
               sum_count_in = sum_count_ff + CW'(1);
            end else begin
               drop_in = 1'b1;
            end
            state_in = ST_ADD_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            rsp_valid_in = 1'b1;
            out_digit_in = sum_rdata;
            out_last_in  = (rem_ff == RW'(1));
            out_drop_in  = drop_ff;
            state_in     = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rem_ff == RW'(1)) begin
                  sum_count_in = '0;
                  carry_in     = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  rem_in   = rem_ff - RW'(1);
                  ptr_in   = ptr_ff - AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         carry_ff     <= 1'b0;
         drop_ff      <= 1'b0;
         sum_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         carry_ff     <= carry_in;
         drop_ff      <= drop_in;
         sum_count_ff <= sum_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_live_ff    <= a_live_in;
      b_live_ff    <= b_live_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      out_digit_ff <= out_digit_in;
      out_last_ff  <= out_last_in;
      out_drop_ff  <= out_drop_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_digit_out     = out_digit_ff;
   assign rsp_last_digit    = out_last_ff;
   assign rsp_digit_dropped = out_drop_ff;

   dsa_stack #(.DEPTH(DEPTH)) u_stack_a (
      .clock (clock),
      .reset (reset),
      .ctl   (a_ctl),
      .sts   (a_sts),
      .rdata (a_rdata)
   );

   dsa_stack #(.DEPTH(DEPTH)) u_stack_b (
      .clock (clock),
      .reset (reset),
      .ctl   (b_ctl),
      .sts   (b_sts),
      .rdata (b_rdata)
   );

   // sum digits, least significant at address zero
   dsa_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_count_ff[AW-1:0]),
      .wdata (fix_sum[DIGIT_W-1:0]),
      .raddr (ptr_ff),
      .rdata (sum_rdata)
   );

endmodule

### rtl/dsa_checker.sv
module dsa_checker import dsa_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [DIGIT_W-1:0] rsp_digit_out,
   input logic               rsp_last_digit
);

   // a stalled result item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item withdrawn while stalled");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_out <= DIGIT_W'(MAX_DIGIT))
      else $error("sum digit out of decimal range");

   // no new request is taken while a sum is being delivered
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req accepted during emission");

   // after the final digit the block goes quiet
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_digit |=> !rsp_valid && !req_stall)
      else $error("activity after final digit");

endmodule

bind decimal_digit_string_adder dsa_checker u_dsa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_digit_out  (rsp_digit_out),
   .rsp_last_digit (rsp_last_digit)
);
